### rtl/core/rbst_pkg.sv
// Shared widths, types and constants for the ray/box slab test.
// No dependencies; used by every module under rtl/core.
package rbst_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// numerator (+-1 - origin) before scaling, signed
	localparam int NUM_W     = WORD_BITS + 2;
	// scaled numerator magnitude and quotient magnitude
	localparam int DVD_W     = WORD_BITS + FRAC_BITS + 1;
	// signed quotient
	localparam int Q_W       = DVD_W + 1;
	// divider latency: operand stage, one stage per quotient bit, sign stage
	localparam int DIV_LAT   = DVD_W + 2;
	localparam int MERGE_LAT = 3;
	localparam int TOTAL_LAT = DIV_LAT + MERGE_LAT;

	localparam logic signed [NUM_W-1:0] ONE_NUM = NUM_W'(1) <<< FRAC_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [NUM_W-1:0]     num_t;
	typedef logic signed [Q_W-1:0]       quot_t;

	// per-axis side band that rides along with the divisions
	typedef struct packed {
		logic zero;     // direction component is zero
		logic outside;  // origin outside [-1, +1] on this axis
		logic dneg;     // direction component negative
	} axis_flag_t;

	typedef struct packed {
		logic                 valid;
		axis_flag_t [2:0]     ax;
	} ctl_t;

endpackage

### rtl/core/rbst_divider.sv
// Pipelined signed divider: (num * 2^FRAC_BITS) / den, truncated toward zero.
// One quotient bit per stage, restoring. Depends on rbst_pkg.
module rbst_divider (
	input  logic                 clk,
	input  rbst_pkg::num_t       num,
	input  rbst_pkg::word_t      den,
	output rbst_pkg::quot_t      quo
);

	localparam int W  = rbst_pkg::WORD_BITS;
	localparam int DW = rbst_pkg::DVD_W;

	logic [W-1:0]  rem_s [0:DW];
	logic [DW-1:0] dq_s  [0:DW];
	logic [W-1:0]  dmag_s[0:DW];
	logic          neg_s [0:DW];
	rbst_pkg::quot_t quo_q;

	logic [rbst_pkg::NUM_W-1:0] nmag;
	logic [W-1:0]               dmag;

	// operand stage: magnitudes and result sign
	always_comb begin
		nmag = num[rbst_pkg::NUM_W-1] ? rbst_pkg::NUM_W'(-num) : rbst_pkg::NUM_W'(num);
		dmag = den[W-1] ? W'(-den) : W'(den);
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		dq_s[0]   <= {nmag[rbst_pkg::NUM_W-2:0], {rbst_pkg::FRAC_BITS{1'b0}}};
		dmag_s[0] <= dmag;
		neg_s[0]  <= num[rbst_pkg::NUM_W-1] ^ den[W-1];
	end

	// one restoring step per stage
	for (genvar k = 0; k < DW; k++) begin : g_step
		logic [W-1:0] sh;
		logic         ge;
		always_comb begin
			sh = {rem_s[k][W-2:0], dq_s[k][DW-1]};
			ge = (sh >= dmag_s[k]);
		end
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? (sh - dmag_s[k]) : sh;
			dq_s[k+1]   <= {dq_s[k][DW-2:0], ge};
			dmag_s[k+1] <= dmag_s[k];
			neg_s[k+1]  <= neg_s[k];
		end
	end

	// sign stage
	always_ff @(posedge clk) begin
		if (neg_s[DW])
			quo_q <= -$signed({1'b0, dq_s[DW]});
		else
			quo_q <= $signed({1'b0, dq_s[DW]});
	end

	assign quo = quo_q;

endmodule

### rtl/core/rbst_merge.sv
// Slab merge: swaps per-axis distances, keeps max entry / min exit,
// then decides hit and saturates. Three stages. Depends on rbst_pkg.
module rbst_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rbst_pkg::ctl_t       ctl,
	input  rbst_pkg::quot_t      q_lo [3],
	input  rbst_pkg::quot_t      q_hi [3],
	output logic                 strobe,
	output logic                 hit,
	output rbst_pkg::word_t      t_near,
	output rbst_pkg::word_t      t_far
);

	localparam int W = rbst_pkg::WORD_BITS;
	localparam rbst_pkg::quot_t W_MAX = rbst_pkg::Q_W'({1'b0, {(W-1){1'b1}}});
	localparam rbst_pkg::quot_t W_MIN = -W_MAX - rbst_pkg::Q_W'(1);

	rbst_pkg::quot_t lo_a [3];
	rbst_pkg::quot_t hi_a [3];
	logic            use_a[3];
	logic            miss;
	logic            any_xy;
	rbst_pkg::quot_t ent_xy, ext_xy;

	logic            vld_s1, miss_s1, any_s1, zuse_s1;
	rbst_pkg::quot_t ent_s1, ext_s1, zlo_s1, zhi_s1;

	logic            any_xyz;
	rbst_pkg::quot_t ent_xyz, ext_xyz;
	logic            vld_s2, miss_s2, any_s2;
	rbst_pkg::quot_t ent_s2, ext_s2;

	logic            hit_c;
	rbst_pkg::word_t near_c, far_c;

	// stage 1: swap on negative direction, merge x and y
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo_a[a]  = ctl.ax[a].dneg ? q_hi[a] : q_lo[a];
			hi_a[a]  = ctl.ax[a].dneg ? q_lo[a] : q_hi[a];
			use_a[a] = !ctl.ax[a].zero;
		end
		miss = (ctl.ax[0].zero & ctl.ax[0].outside) |
		       (ctl.ax[1].zero & ctl.ax[1].outside) |
		       (ctl.ax[2].zero & ctl.ax[2].outside);
		any_xy = use_a[0] | use_a[1];
		if (use_a[0] && use_a[1]) begin
			ent_xy = (lo_a[0] > lo_a[1]) ? lo_a[0] : lo_a[1];
			ext_xy = (hi_a[0] < hi_a[1]) ? hi_a[0] : hi_a[1];
		end else if (use_a[0]) begin
			ent_xy = lo_a[0];
			ext_xy = hi_a[0];
		end else begin
			ent_xy = lo_a[1];
			ext_xy = hi_a[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		miss_s1 <= miss;
		any_s1  <= any_xy;
		ent_s1  <= ent_xy;
		ext_s1  <= ext_xy;
		zuse_s1 <= use_a[2];
		zlo_s1  <= lo_a[2];
		zhi_s1  <= hi_a[2];
	end

	// stage 2: merge z
	always_comb begin
		any_xyz = any_s1 | zuse_s1;
		if (any_s1 && zuse_s1) begin
			ent_xyz = (ent_s1 > zlo_s1) ? ent_s1 : zlo_s1;
			ext_xyz = (ext_s1 < zhi_s1) ? ext_s1 : zhi_s1;
		end else if (any_s1) begin
			ent_xyz = ent_s1;
			ext_xyz = ext_s1;
		end else begin
			ent_xyz = zlo_s1;
			ext_xyz = zhi_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		miss_s2 <= miss_s1;
		any_s2  <= any_xyz;
		ent_s2  <= ent_xyz;
		ext_s2  <= ext_xyz;
	end

	// stage 3: hit decision and saturation to the word range
	always_comb begin
		hit_c = !miss_s2 && (!any_s2 || (ext_s2 > ent_s2));
		if (!hit_c) begin
			near_c = '0;
			far_c  = '0;
		end else if (!any_s2) begin
			near_c = W_MIN[W-1:0];
			far_c  = W_MAX[W-1:0];
		end else begin
			if (ent_s2 > W_MAX)      near_c = W_MAX[W-1:0];
			else if (ent_s2 < W_MIN) near_c = W_MIN[W-1:0];
			else                     near_c = ent_s2[W-1:0];
			if (ext_s2 > W_MAX)      far_c = W_MAX[W-1:0];
			else if (ext_s2 < W_MIN) far_c = W_MIN[W-1:0];
			else                     far_c = ext_s2[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		hit    <= hit_c;
		t_near <= near_c;
		t_far  <= far_c;
	end

endmodule

### rtl/core/ray_unit_box_slab_test.sv
// Top level of the ray / unit-box slab test.
// Depends on rbst_pkg, rbst_divider and rbst_merge.
//
// Usage:
//   A ray word (origin_x/y/z, dir_x/y/z, signed Q16.16) is taken at a
//   rising edge with start high and busy low. busy is always low: the
//   block is a fully pipelined datapath and takes one ray every cycle.
//   Each ray gives one result word (hit, t_near, t_far) on the result
//   ports for exactly one cycle, marked by strobe, once the ray has
//   passed through the divider and merge stages. Results leave in the
//   order rays arrived.
//   Latency is set by the six slab dividers, which produce one quotient
//   bit per stage, plus three merge and saturation stages.
//   Throughput: one ray per cycle, sustained.
//   The receiver cannot stall, so no back-pressure exists anywhere.
//   Reset clears only control and valid state; no result is shown until a ray has
//   passed through the whole pipeline.
//   On a miss hit is 0 and both distances are 0.
module ray_unit_box_slab_test (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rbst_pkg::word_t origin_x,
	input  rbst_pkg::word_t origin_y,
	input  rbst_pkg::word_t origin_z,
	input  rbst_pkg::word_t dir_x,
	input  rbst_pkg::word_t dir_y,
	input  rbst_pkg::word_t dir_z,
	output logic            strobe,
	output logic            hit,
	output rbst_pkg::word_t t_near,
	output rbst_pkg::word_t t_far
);

	localparam int W = rbst_pkg::WORD_BITS;

	rbst_pkg::word_t  org  [3];
	rbst_pkg::word_t  dir  [3];
	rbst_pkg::num_t   o_ext[3];
	rbst_pkg::num_t   n_lo [3];
	rbst_pkg::num_t   n_hi [3];
	rbst_pkg::quot_t  q_lo [3];
	rbst_pkg::quot_t  q_hi [3];
	rbst_pkg::ctl_t   ctl_in;
	rbst_pkg::ctl_t   ctl_line [rbst_pkg::DIV_LAT];

	assign busy = 1'b0;

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	// numerators and per-axis flags for the incoming word
	always_comb begin
		ctl_in.valid = start & !busy;
		for (int a = 0; a < 3; a++) begin
			o_ext[a] = {{2{org[a][W-1]}}, org[a]};
			n_lo[a]  = -rbst_pkg::ONE_NUM - o_ext[a];
			n_hi[a]  = rbst_pkg::ONE_NUM - o_ext[a];
			ctl_in.ax[a].zero    = (dir[a] == '0);
			ctl_in.ax[a].outside = (o_ext[a] < -rbst_pkg::ONE_NUM) ||
			                       (o_ext[a] > rbst_pkg::ONE_NUM);
			ctl_in.ax[a].dneg    = dir[a][W-1];
		end
	end

	// six slab dividers, two per axis
	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbst_divider u_div_lo (
			.clk (clk),
			.num (n_lo[a]),
			.den (dir[a]),
			.quo (q_lo[a])
		);
		rbst_divider u_div_hi (
			.clk (clk),
			.num (n_hi[a]),
			.den (dir[a]),
			.quo (q_hi[a])
		);
	end

	// control line matched to the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbst_pkg::DIV_LAT; i++)
				ctl_line[i] <= '0;
		end else begin
			ctl_line[0] <= ctl_in;
			for (int i = 1; i < rbst_pkg::DIV_LAT; i++)
				ctl_line[i] <= ctl_line[i-1];
		end
	end

	rbst_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_line[rbst_pkg::DIV_LAT-1]),
		.q_lo   (q_lo),
		.q_hi   (q_hi),
		.strobe (strobe),
		.hit    (hit),
		.t_near (t_near),
		.t_far  (t_far)
	);

	// a miss reports zero distances
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !hit |-> (t_near == '0) && (t_far == '0))
		else $error("miss with non-zero distances");

	// a hit never has entry beyond exit
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && hit |-> (t_near <= t_far))
		else $error("hit with entry beyond exit");

	// the result strobe follows the end of the control line
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(ctl_line[rbst_pkg::DIV_LAT-1].valid, 3))
		else $error("result strobe without a ray behind it");

endmodule
